// ===== rtl/afrc_pkg.sv =====
// Shared types, codes, character constants and helpers of the ASCII frame receiver.
package afrc_pkg;

  localparam int BUFFER_BYTES_DEF = 512;
  localparam int FILL_CAP         = 500;
  localparam int SCAN_MIN         = 6;
  localparam int FILL_W           = 10;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_V     = 8'h56;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_M     = 2'd1;
  localparam logic [1:0] KIND_S     = 2'd2;
  localparam logic [1:0] KIND_V     = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_NOCOMMA  = 2'd2;
  localparam logic [1:0] ST_MISMATCH = 2'd3;

  localparam logic [1:0] CAUSE_LINE    = 2'd0;
  localparam logic [1:0] CAUSE_TRAILER = 2'd1;
  localparam logic [1:0] CAUSE_GAP     = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_MSV, S_MRK, S_MHX, S_CK1, S_DEC, S_CK2, S_EMIT
  } afrc_state_t;

  typedef enum logic [1:0] {PH_LEAD, PH_NUM, PH_X, PH_DONE} hex_phase_t;

  typedef struct packed {
    logic       clear;
    logic       valid;
    logic [7:0] data;
  } hex_in_t;

  function automatic logic hex_ok(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    else v = 8'h00;
    return v[3:0];
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_msv(input logic [7:0] c);
    return (c == CH_M) || (c == CH_S) || (c == CH_V);
  endfunction

  function automatic logic [1:0] kind_of(input logic [7:0] c);
    logic [1:0] k;
    if (c == CH_M) k = KIND_M;
    else if (c == CH_S) k = KIND_S;
    else if (c == CH_V) k = KIND_V;
    else k = KIND_OTHER;
    return k;
  endfunction

endpackage

// ===== rtl/afrc_hexparse.sv =====
// Byte-serial reader of the hex checksum text that follows the last comma of a frame.
module afrc_hexparse (
  input  logic              clk,
  input  logic              rst_n,
  input  afrc_pkg::hex_in_t hin,
  output logic [7:0]        rsum
);

  localparam logic [4:0] SIG_FULL = 5'd16;

  afrc_pkg::hex_phase_t phase_r, phase_nxt;
  logic       neg_r, neg_nxt, any_r, any_nxt, zf_r, zf_nxt;
  logic       lnz_r, lnz_nxt, big_r, big_nxt;
  logic [4:0] sig_r, sig_nxt;
  logic [3:0] top_r, top_nxt;
  logic [7:0] low_r, low_nxt;
  logic       take, is_d, pos_ovf, neg_ovf;
  logic [3:0] d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= afrc_pkg::PH_DONE;
      neg_r   <= 1'b0;
      any_r   <= 1'b0;
      zf_r    <= 1'b0;
      lnz_r   <= 1'b0;
      big_r   <= 1'b0;
      sig_r   <= '0;
      top_r   <= '0;
      low_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      any_r   <= any_nxt;
      zf_r    <= zf_nxt;
      lnz_r   <= lnz_nxt;
      big_r   <= big_nxt;
      sig_r   <= sig_nxt;
      top_r   <= top_nxt;
      low_r   <= low_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    any_nxt   = any_r;
    zf_nxt    = zf_r;
    lnz_nxt   = lnz_r;
    big_nxt   = big_r;
    sig_nxt   = sig_r;
    top_nxt   = top_r;
    low_nxt   = low_r;
    take      = 1'b0;
    is_d      = afrc_pkg::hex_ok(hin.data);
    d         = afrc_pkg::hex_nib(hin.data);
    if (hin.clear) begin
      phase_nxt = afrc_pkg::PH_LEAD;
      neg_nxt   = 1'b0;
      any_nxt   = 1'b0;
      zf_nxt    = 1'b0;
      lnz_nxt   = 1'b0;
      big_nxt   = 1'b0;
      sig_nxt   = '0;
      top_nxt   = '0;
      low_nxt   = '0;
    end else if (hin.valid) begin
      unique case (phase_r)
        afrc_pkg::PH_LEAD: begin
          if (afrc_pkg::is_blank(hin.data)) begin
            phase_nxt = afrc_pkg::PH_LEAD;
          end else if (hin.data == afrc_pkg::CH_PLUS || hin.data == afrc_pkg::CH_MINUS) begin
            neg_nxt   = (hin.data == afrc_pkg::CH_MINUS);
            phase_nxt = afrc_pkg::PH_NUM;
          end else if (is_d) begin
            take      = 1'b1;
            zf_nxt    = (d == 4'd0);
            phase_nxt = afrc_pkg::PH_NUM;
          end else begin
            phase_nxt = afrc_pkg::PH_DONE;
          end
        end
        afrc_pkg::PH_NUM: begin
          if (is_d) begin
            take   = 1'b1;
            zf_nxt = !any_r && (d == 4'd0);
          end else if ((hin.data | 8'h20) == afrc_pkg::CH_LOW_X && zf_r) begin
            zf_nxt    = 1'b0;
            phase_nxt = afrc_pkg::PH_X;
          end else begin
            phase_nxt = afrc_pkg::PH_DONE;
          end
        end
        afrc_pkg::PH_X: begin
          if (is_d) begin
            take      = 1'b1;
            phase_nxt = afrc_pkg::PH_NUM;
          end else begin
            phase_nxt = afrc_pkg::PH_DONE;
          end
        end
        afrc_pkg::PH_DONE: phase_nxt = afrc_pkg::PH_DONE;
        default: phase_nxt = afrc_pkg::PH_DONE;
      endcase
      if (take) begin
        any_nxt = 1'b1;
        if (!big_r) begin
          if (sig_r == SIG_FULL) begin
            big_nxt = 1'b1;
          end else begin
            low_nxt = {low_r[3:0], d};
            if (sig_r == 5'd0) begin
              if (d != 4'd0) begin
                sig_nxt = 5'd1;
                top_nxt = d;
              end
            end else begin
              sig_nxt = sig_r + 5'd1;
              if (d != 4'd0) lnz_nxt = 1'b1;
            end
          end
        end
      end
    end
  end

  // Saturation of the 64-bit conversion, judged from the digit count and the top digit.
  always_comb begin
    pos_ovf = big_r || (sig_r == SIG_FULL && top_r[3]);
    neg_ovf = big_r || (sig_r == SIG_FULL &&
              (top_r > 4'd8 || (top_r == 4'd8 && lnz_r)));
    if (neg_r) rsum = neg_ovf ? 8'h00 : (8'h00 - low_r);
    else rsum = pos_ovf ? 8'hFF : low_r;
  end

endmodule

// ===== rtl/ascii_frame_receiver_checksum_top.sv =====
// Top level of the ASCII frame receiver: ring buffer, trailer scan and frame check.
// Flow: a tick is handled in the idle state; a data byte is stored below the cap and then the
// trailer scan walks the held bytes through the read port in each of its passes; a closed frame
// is read once from its first byte, once more from the byte after its last comma, then emitted.
// Throughput: one transaction in flight; in_ready stays low until the scan or check is done, as
// the single read port of the byte store is walked once per scan pass.
// Reset (synchronous, rst_n low): empty buffer, idle count zero, gap register 50; the byte
// store itself is not cleared, as only written entries are ever read.
module ascii_frame_receiver_checksum_top #(
  parameter int BUFFER_BYTES = afrc_pkg::BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_frame_kind,
  output logic [1:0]  out_status,
  output logic [1:0]  out_end_cause,
  output logic [9:0]  out_body_length,
  output logic [7:0]  out_computed_sum,
  output logic [7:0]  out_received_sum,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int FW    = afrc_pkg::FILL_W;
  localparam int AW    = $clog2(BUFFER_BYTES);
  localparam int SW    = ((AW > FW) ? AW : FW) + 1;
  localparam int LIMIT = (BUFFER_BYTES < afrc_pkg::FILL_CAP) ? BUFFER_BYTES
                                                             : afrc_pkg::FILL_CAP;

  // Ring addressing: base plus offset, folded once since both stay below the depth.
  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] b, input logic [FW-1:0] o);
    logic [SW-1:0] s;
    s = SW'(b) + SW'(o);
    if (s >= SW'(BUFFER_BYTES)) s = s - SW'(BUFFER_BYTES);
    return s[AW-1:0];
  endfunction

  // The byte store: one write port, one registered read port.
  logic [7:0]    mem [BUFFER_BYTES];
  logic [7:0]    rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;

  afrc_pkg::afrc_state_t state_r, state_nxt;
  logic [AW-1:0] start_r, start_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [15:0]   idle_r, idle_nxt, gap_r, gap_nxt, idle_inc;
  logic          seen_r, seen_nxt;
  // Read stream: offset issued to the store, end of the stream, and the returning tag.
  logic [FW-1:0] rd_off_r, rd_off_nxt, end_r, end_nxt, po_r, po_nxt;
  logic          pv_r, pv_nxt;
  // Marker search window and the candidate marker position.
  logic [7:0]    b1_r, b1_nxt, b2_r, b2_nxt;
  logic [FW-1:0] mk_p_r, mk_p_nxt;
  logic          h1_ok_r, h1_ok_nxt;
  // Frame check context.
  logic [FW-1:0] ck_len_r, ck_len_nxt, idx_r, idx_nxt;
  logic [1:0]    ck_cause_r, ck_cause_nxt, kind_r, kind_nxt, st_r, st_nxt;
  logic [7:0]    run_sum_r, run_sum_nxt, pre_sum_r, pre_sum_nxt;
  logic          found_r, found_nxt, cmp_r, cmp_nxt;
  // Result register.
  logic          out_valid_r, out_valid_nxt, out_load;
  logic [1:0]    out_kind_r, out_status_r, out_cause_r;
  logic [9:0]    out_body_r;
  logic [7:0]    out_csum_r, out_rsum_r;

  logic          stream_st, issue, ck_go;
  logic [FW-1:0] ck_len_v;
  logic [1:0]    ck_cause_v;
  logic [7:0]    b;
  afrc_pkg::hex_in_t hin;
  logic [7:0]    hex_rsum;

  afrc_hexparse u_hex (
    .clk   (clk),
    .rst_n (rst_n),
    .hin   (hin),
    .rsum  (hex_rsum)
  );

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= in_data_byte;
    rd_data_r <= mem[mem_ra];
  end

  assign mem_wa   = wrap(start_r, fill_r);
  assign mem_ra   = wrap(start_r, rd_off_r);
  assign idle_inc = (idle_r == 16'hFFFF) ? idle_r : idle_r + 16'd1;
  assign b        = rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= afrc_pkg::S_IDLE;
      start_r     <= '0;
      fill_r      <= '0;
      idle_r      <= '0;
      seen_r      <= 1'b0;
      gap_r       <= 16'd50;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      fill_r      <= fill_nxt;
      idle_r      <= idle_nxt;
      seen_r      <= seen_nxt;
      gap_r       <= gap_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_off_r   <= rd_off_nxt;
    end_r      <= end_nxt;
    po_r       <= po_nxt;
    b1_r       <= b1_nxt;
    b2_r       <= b2_nxt;
    mk_p_r     <= mk_p_nxt;
    h1_ok_r    <= h1_ok_nxt;
    ck_len_r   <= ck_len_nxt;
    ck_cause_r <= ck_cause_nxt;
    kind_r     <= kind_nxt;
    st_r       <= st_nxt;
    idx_r      <= idx_nxt;
    run_sum_r  <= run_sum_nxt;
    pre_sum_r  <= pre_sum_nxt;
    found_r    <= found_nxt;
    cmp_r      <= cmp_nxt;
    if (out_load) begin
      out_kind_r   <= kind_r;
      out_status_r <= cmp_r ? ((pre_sum_r == hex_rsum) ? afrc_pkg::ST_OK
                                                       : afrc_pkg::ST_MISMATCH) : st_r;
      out_cause_r  <= ck_cause_r;
      out_body_r   <= cmp_r ? idx_r : '0;
      out_csum_r   <= cmp_r ? pre_sum_r : 8'h00;
      out_rsum_r   <= cmp_r ? hex_rsum : 8'h00;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    start_nxt    = start_r;
    fill_nxt     = fill_r;
    idle_nxt     = idle_r;
    seen_nxt     = seen_r;
    gap_nxt      = cfg_wr_en ? cfg_wr_data : gap_r;
    rd_off_nxt   = rd_off_r;
    end_nxt      = end_r;
    b1_nxt       = b1_r;
    b2_nxt       = b2_r;
    mk_p_nxt     = mk_p_r;
    h1_ok_nxt    = h1_ok_r;
    ck_len_nxt   = ck_len_r;
    ck_cause_nxt = ck_cause_r;
    kind_nxt     = kind_r;
    st_nxt       = st_r;
    idx_nxt      = idx_r;
    run_sum_nxt  = run_sum_r;
    pre_sum_nxt  = pre_sum_r;
    found_nxt    = found_r;
    cmp_nxt      = cmp_r;
    in_ready     = 1'b0;
    mem_we       = 1'b0;
    out_load     = 1'b0;
    ck_go        = 1'b0;
    ck_len_v     = fill_r;
    ck_cause_v   = afrc_pkg::CAUSE_LINE;
    hin.clear    = 1'b0;
    hin.valid    = 1'b0;
    hin.data     = rd_data_r;

    // The read stream advances by itself in the walking states; a state that starts a new
    // walk overrides the offset and drops the read still in flight.
    stream_st = (state_r inside {afrc_pkg::S_MSV, afrc_pkg::S_MRK, afrc_pkg::S_MHX,
                                 afrc_pkg::S_CK1, afrc_pkg::S_CK2});
    issue     = stream_st && (rd_off_r < end_r);
    pv_nxt    = issue;
    po_nxt    = rd_off_r;
    if (issue) rd_off_nxt = rd_off_r + 1'b1;

    unique case (state_r)
      afrc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_req_type) begin
            idle_nxt = idle_inc;
            if (seen_r && fill_r != '0 && idle_inc >= gap_r) begin
              ck_go      = 1'b1;
              ck_cause_v = afrc_pkg::CAUSE_GAP;
            end
          end else begin
            seen_nxt = 1'b1;
            idle_nxt = '0;
            if (in_data_byte == afrc_pkg::CH_CR || in_data_byte == afrc_pkg::CH_LF) begin
              if (fill_r != '0) ck_go = 1'b1;
            end else begin
              if (fill_r < FW'(LIMIT)) begin
                mem_we   = 1'b1;
                fill_nxt = fill_r + 1'b1;
              end
              state_nxt = afrc_pkg::S_SCAN;
            end
          end
        end
      end
      afrc_pkg::S_SCAN: begin
        if (fill_r < FW'(afrc_pkg::SCAN_MIN)) begin
          state_nxt = afrc_pkg::S_IDLE;
        end else begin
          state_nxt  = afrc_pkg::S_MSV;
          rd_off_nxt = '0;
          end_nxt    = fill_r;
        end
      end
      afrc_pkg::S_MSV: begin
        if (pv_r) begin
          if (afrc_pkg::is_msv(b)) begin
            start_nxt  = wrap(start_r, po_r);
            fill_nxt   = fill_r - po_r;
            state_nxt  = afrc_pkg::S_MRK;
            rd_off_nxt = '0;
            end_nxt    = fill_r - po_r;
            pv_nxt     = 1'b0;
          end else if (po_r + 1'b1 == fill_r) begin
            fill_nxt  = '0;
            state_nxt = afrc_pkg::S_IDLE;
          end
        end
      end
      afrc_pkg::S_MRK: begin
        if (pv_r) begin
          b2_nxt = b1_r;
          b1_nxt = b;
          if (po_r >= FW'(2) && b2_r == afrc_pkg::CH_COMMA &&
              b1_r == afrc_pkg::CH_ZERO && b == afrc_pkg::CH_LOW_X) begin
            if ({1'b0, po_r} + 11'd3 > {1'b0, fill_r}) begin
              state_nxt = afrc_pkg::S_IDLE;
            end else begin
              mk_p_nxt  = po_r - FW'(2);
              state_nxt = afrc_pkg::S_MHX;
            end
          end else if (po_r + 1'b1 == fill_r) begin
            state_nxt = afrc_pkg::S_IDLE;
          end
        end
      end
      afrc_pkg::S_MHX: begin
        if (pv_r) begin
          if (po_r == mk_p_r + FW'(3)) begin
            h1_ok_nxt = afrc_pkg::hex_ok(b);
          end else if (h1_ok_r && afrc_pkg::hex_ok(b)) begin
            ck_go      = 1'b1;
            ck_len_v   = mk_p_r + FW'(5);
            ck_cause_v = afrc_pkg::CAUSE_TRAILER;
          end else begin
            // A false marker: skip past its comma and scan again.
            start_nxt = wrap(start_r, mk_p_r + 1'b1);
            fill_nxt  = fill_r - (mk_p_r + 1'b1);
            state_nxt = afrc_pkg::S_SCAN;
            pv_nxt    = 1'b0;
          end
        end
      end
      afrc_pkg::S_CK1: begin
        if (pv_r) begin
          if (po_r == '0) kind_nxt = afrc_pkg::kind_of(b);
          if (b == afrc_pkg::CH_COMMA) begin
            found_nxt   = 1'b1;
            idx_nxt     = po_r;
            pre_sum_nxt = run_sum_r;
          end
          run_sum_nxt = run_sum_r + b;
          if (po_r + 1'b1 == end_r) state_nxt = afrc_pkg::S_DEC;
        end
      end
      afrc_pkg::S_DEC: begin
        hin.clear = 1'b1;
        cmp_nxt   = 1'b0;
        if (ck_len_r < FW'(4)) begin
          st_nxt    = afrc_pkg::ST_SHORT;
          state_nxt = afrc_pkg::S_EMIT;
        end else if (!found_r || idx_r == '0) begin
          st_nxt    = afrc_pkg::ST_NOCOMMA;
          state_nxt = afrc_pkg::S_EMIT;
        end else begin
          cmp_nxt = 1'b1;
          if (idx_r + 1'b1 < ck_len_r) begin
            state_nxt  = afrc_pkg::S_CK2;
            rd_off_nxt = idx_r + 1'b1;
            end_nxt    = ck_len_r;
          end else begin
            state_nxt = afrc_pkg::S_EMIT;
          end
        end
      end
      afrc_pkg::S_CK2: begin
        if (pv_r) begin
          hin.valid = 1'b1;
          if (po_r + 1'b1 == end_r) state_nxt = afrc_pkg::S_EMIT;
        end
      end
      afrc_pkg::S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          if (ck_cause_r == afrc_pkg::CAUSE_TRAILER) begin
            start_nxt = wrap(start_r, ck_len_r);
            fill_nxt  = fill_r - ck_len_r;
          end else begin
            fill_nxt = '0;
          end
          state_nxt = afrc_pkg::S_IDLE;
        end
      end
      default: state_nxt = afrc_pkg::S_IDLE;
    endcase

    // Opening a frame check: first pass finds the kind, last comma and body sum.
    if (ck_go) begin
      state_nxt    = afrc_pkg::S_CK1;
      ck_len_nxt   = ck_len_v;
      ck_cause_nxt = ck_cause_v;
      rd_off_nxt   = '0;
      end_nxt      = ck_len_v;
      pv_nxt       = 1'b0;
      run_sum_nxt  = 8'h00;
      pre_sum_nxt  = 8'h00;
      found_nxt    = 1'b0;
      idx_nxt      = '0;
      kind_nxt     = afrc_pkg::KIND_OTHER;
    end

    out_valid_nxt = out_load || (out_valid_r && !out_ready);
  end

  assign out_valid        = out_valid_r;
  assign out_frame_kind   = out_kind_r;
  assign out_status       = out_status_r;
  assign out_end_cause    = out_cause_r;
  assign out_body_length  = out_body_r;
  assign out_computed_sum = out_csum_r;
  assign out_received_sum = out_rsum_r;

  // The buffer never holds more than its cap.
  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(LIMIT))
    else $error("fill count above cap");

  // The ring start stays inside the store.
  a_start_rng: assert property (@(posedge clk) disable iff (!rst_n)
    start_r <= AW'(BUFFER_BYTES - 1))
    else $error("ring start outside store");

  // A returning read always belongs to the current walk.
  a_read_tag: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> (po_r < end_r))
    else $error("read beyond walk end");

  // A tick before any byte has arrived never opens a frame check.
  a_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_req_type && !seen_r) |=> (state_r == afrc_pkg::S_IDLE))
    else $error("frame closed before any byte");

endmodule
